// ----- rtl/tmpc_pkg.sv -----
// Shared constants, color tables and helpers for the minimap pixel colorizer.
package tmpc_pkg;

	localparam int CoordBitsDefault = 12;
	localparam int FadeTilesDefault = 5;

	localparam int ElevBits   = 16;
	localparam int ComplexBits = 16;
	localparam int MapDimBits = 13;
	localparam int ChanBits   = 8;
	localparam int RgbBits    = 3 * ChanBits;

	// configuration register indexes
	localparam int CfgIndexBits = 4;
	localparam int CfgDataBits  = 16;
	localparam logic [CfgIndexBits-1:0] CfgMapWidth        = 4'd0;
	localparam logic [CfgIndexBits-1:0] CfgMapHeight       = 4'd1;
	localparam logic [CfgIndexBits-1:0] CfgSelectionValid  = 4'd2;
	localparam logic [CfgIndexBits-1:0] CfgSelectedComplex = 4'd3;

	localparam logic [MapDimBits-1:0] MapDimReset = 13'd256;

	// terrain blend: weight m over BlendDen, levels of ElevStep summed elevation
	localparam int BlendDen = 5;
	localparam int BlendMax = 5;
	localparam int ElevStep = 20;

	// tile color codes: grass levels, water levels, then the flat colors
	localparam int NumColors  = 16;
	localparam int ColorBits  = 4;
	localparam int ColorGrass = 0;
	localparam int ColorWater = 6;
	localparam logic [ColorBits-1:0] ColorSand     = 4'd12;
	localparam logic [ColorBits-1:0] ColorPath     = 4'd13;
	localparam logic [ColorBits-1:0] ColorBuilding = 4'd14;
	localparam logic [ColorBits-1:0] ColorSelected = 4'd15;

	localparam int GrassHi [3] = '{192, 199, 65};
	localparam int GrassLo [3] = '{98, 122, 51};
	localparam int Sand    [3] = '{245, 237, 186};
	localparam int WaterHi [3] = '{110, 169, 167};
	localparam int WaterLo [3] = '{44, 101, 118};
	localparam int Path    [3] = '{154, 99, 72};
	localparam int Bldg    [3] = '{157, 48, 59};
	localparam int Backgr  [3] = '{255, 202, 168};
	localparam int Selected[3] = '{239, 239, 230};

	localparam logic [RgbBits-1:0] BackgrRgb = {8'd168, 8'd202, 8'd255};

	function automatic int blend_chan(int a, int b, int m);
		return a + (m * (b - a)) / BlendDen;
	endfunction

	// channel ch (0 red, 1 green, 2 blue) of tile color code id, before the edge fade
	function automatic int base_chan(int id, int ch);
		int v;
		v = 0;
		if (id < ColorWater)
			v = blend_chan(GrassLo[ch], GrassHi[ch], id - ColorGrass);
		else if (id < int'(ColorSand))
			v = blend_chan(WaterHi[ch], WaterLo[ch], id - ColorWater);
		else if (id == int'(ColorSand))
			v = Sand[ch];
		else if (id == int'(ColorPath))
			v = Path[ch];
		else if (id == int'(ColorBuilding))
			v = Bldg[ch];
		else
			v = Selected[ch];
		return v;
	endfunction

endpackage

// ----- rtl/terrain_minimap_pixel_colorizer_core.sv -----
// Minimap pixel colorizer: one RGB color per map tile, terrain plus overrides plus edge fade.
//
// Input stream s_axis: one tile per transfer; tdata carries position, four corner
// elevations, path and building flags and the complex index. Output stream m_axis:
// one color per tile, in order, tdata = red, green, blue from the low byte up.
// Config channel cfg_*: register index and data, always ready; write only while idle.
//   0 map_width, 1 map_height, 2 selection_valid, 3 selection index; others ignored.
// The pipeline is an input register, then the color is looked up and lands in
// the output register. Throughput is one tile per clock while m_axis_tready is high;
// the path from the input register to the output register is the elevation sum, the
// edge distance minimum and a constant color table indexed by color code and fade step.
// Reset (arst_n low) empties both stages and restores map size 256 x 256 with no
// selection. When m_axis_tready is low, the output register holds its color, the
// input register fills, and s_axis_tready drops once both hold a tile; a stage
// frees in the same cycle its content moves on.
module terrain_minimap_pixel_colorizer_core #(
	parameter int COORD_BITS = tmpc_pkg::CoordBitsDefault,
	parameter int FADE_TILES = tmpc_pkg::FadeTilesDefault,
	localparam int InBits    = 2 * COORD_BITS + 4 * tmpc_pkg::ElevBits + 3
		+ tmpc_pkg::ComplexBits,
	localparam int InBytes   = (InBits + 7) / 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tile_x, tile_z, elev_top_left, elev_top_right, elev_bottom_left,
	// elev_bottom_right, on_path, has_building, in_complex, complex_index, zero pad
	input  logic [8*InBytes-1:0] s_axis_tdata,

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// red, green, blue
	output logic [tmpc_pkg::RgbBits-1:0] m_axis_tdata,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tmpc_pkg::CfgIndexBits-1:0] cfg_index,
	input  logic [tmpc_pkg::CfgDataBits-1:0] cfg_data
);

	localparam int Eb = tmpc_pkg::ElevBits;
	localparam int Md = tmpc_pkg::MapDimBits;
	localparam int SumBits  = Eb + 2;
	localparam int DistBits = ((COORD_BITS > Md) ? COORD_BITS : Md) + 1;
	localparam int FadeBits = $clog2(FADE_TILES + 1);
	localparam int StepBits = (FADE_TILES > 1) ? $clog2(FADE_TILES) : 1;
	localparam int PosZ    = COORD_BITS;
	localparam int PosE0   = 2 * COORD_BITS;
	localparam int PosFlag = PosE0 + 4 * Eb;
	localparam int PosCidx = PosFlag + 3;

	// configuration registers
	logic [Md-1:0] map_width_q, map_height_q;
	logic selection_valid_q;
	logic [tmpc_pkg::ComplexBits-1:0] sel_cplx_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q       <= tmpc_pkg::MapDimReset;
			map_height_q      <= tmpc_pkg::MapDimReset;
			selection_valid_q <= 1'b0;
			sel_cplx_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tmpc_pkg::CfgMapWidth:        map_width_q <= cfg_data[Md-1:0];
				tmpc_pkg::CfgMapHeight:       map_height_q <= cfg_data[Md-1:0];
				tmpc_pkg::CfgSelectionValid:  selection_valid_q <= cfg_data[0];
				tmpc_pkg::CfgSelectedComplex: sel_cplx_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic valid_s1, valid_s2;
	logic adv_s1, adv_s2;

	assign adv_s2 = !valid_s2 || m_axis_tready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	logic [COORD_BITS-1:0] tile_x_s1, tile_z_s1;
	logic signed [Eb-1:0] elev_s1 [4];
	logic on_path_s1, has_building_s1, in_complex_s1;
	logic [tmpc_pkg::ComplexBits-1:0] complex_index_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			tile_x_s1 <= s_axis_tdata[COORD_BITS-1:0];
			tile_z_s1 <= s_axis_tdata[PosZ +: COORD_BITS];
			for (int i = 0; i < 4; i++)
				elev_s1[i] <= s_axis_tdata[PosE0 + i*Eb +: Eb];
			on_path_s1       <= s_axis_tdata[PosFlag];
			has_building_s1  <= s_axis_tdata[PosFlag + 1];
			in_complex_s1    <= s_axis_tdata[PosFlag + 2];
			complex_index_s1 <= s_axis_tdata[PosCidx +: tmpc_pkg::ComplexBits];
		end
	end

	// terrain class from the corner sum; levels are compared instead of divided
	localparam int ColorBitsW = tmpc_pkg::ColorBits;
	logic signed [SumBits-1:0] elev_sum;
	logic any_neg, all_neg, sel_hit;
	logic [ColorBitsW-1:0] grass_lvl, water_lvl;
	logic [ColorBitsW-1:0] color_id;

	always_comb begin
		elev_sum = SumBits'(elev_s1[0]) + SumBits'(elev_s1[1])
			+ SumBits'(elev_s1[2]) + SumBits'(elev_s1[3]);
		any_neg = elev_s1[0][Eb-1] | elev_s1[1][Eb-1] | elev_s1[2][Eb-1] | elev_s1[3][Eb-1];
		all_neg = elev_s1[0][Eb-1] & elev_s1[1][Eb-1] & elev_s1[2][Eb-1] & elev_s1[3][Eb-1];
		grass_lvl = '0;
		water_lvl = '0;
		for (int l = 1; l <= tmpc_pkg::BlendMax; l++) begin
			if (elev_sum >= SumBits'(l * tmpc_pkg::ElevStep))
				grass_lvl = ColorBitsW'(l);
			if (elev_sum <= -SumBits'(l * tmpc_pkg::ElevStep))
				water_lvl = ColorBitsW'(l);
		end
		sel_hit = has_building_s1 && in_complex_s1 && selection_valid_q
			&& (complex_index_s1 == sel_cplx_q);
		if (sel_hit)
			color_id = tmpc_pkg::ColorSelected;
		else if (has_building_s1)
			color_id = tmpc_pkg::ColorBuilding;
		else if (on_path_s1)
			color_id = tmpc_pkg::ColorPath;
		else if (all_neg)
			color_id = ColorBitsW'(tmpc_pkg::ColorWater) + water_lvl;
		else if (any_neg)
			color_id = tmpc_pkg::ColorSand;
		else
			color_id = ColorBitsW'(tmpc_pkg::ColorGrass) + grass_lvl;
	end

	// edge distance, saturated at the fade width; zero outside the map
	logic [DistBits-1:0] px, pz, pw, ph, dist_min;
	logic on_map;
	logic [FadeBits-1:0] fade;
	logic [StepBits-1:0] fade_step;

	always_comb begin
		px = DistBits'(tile_x_s1);
		pz = DistBits'(tile_z_s1);
		pw = DistBits'(map_width_q);
		ph = DistBits'(map_height_q);
		on_map = (px < pw) && (pz < ph);
		dist_min = px + DistBits'(1);
		if (pw - px < dist_min)
			dist_min = pw - px;
		if (pz + DistBits'(1) < dist_min)
			dist_min = pz + DistBits'(1);
		if (ph - pz < dist_min)
			dist_min = ph - pz;
		if (!on_map)
			fade = '0;
		else if (dist_min > DistBits'(FADE_TILES))
			fade = FadeBits'(FADE_TILES);
		else
			fade = FadeBits'(dist_min);
		fade_step = StepBits'(fade - FadeBits'(1));
	end

	// faded color for every color code and fade step 1..FADE_TILES
	logic [tmpc_pkg::RgbBits-1:0] fade_tab [tmpc_pkg::NumColors][FADE_TILES];

	for (genvar gi = 0; gi < tmpc_pkg::NumColors; gi++) begin : g_color
		for (genvar gj = 0; gj < FADE_TILES; gj++) begin : g_step
			for (genvar gc = 0; gc < 3; gc++) begin : g_chan
				localparam int Cv = tmpc_pkg::base_chan(gi, gc);
				localparam int Bv = tmpc_pkg::Backgr[gc];
				assign fade_tab[gi][gj][gc*tmpc_pkg::ChanBits +: tmpc_pkg::ChanBits] =
					tmpc_pkg::ChanBits'(Bv + ((gj + 1) * (Cv - Bv)) / FADE_TILES);
			end
		end
	end

	// output register
	logic [tmpc_pkg::RgbBits-1:0] color_s2;

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1)
			color_s2 <= (fade == '0) ? tmpc_pkg::BackgrRgb : fade_tab[color_id][fade_step];
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = color_s2;

endmodule
